[design/alarm_relay_output_controller_defines.svh]
// Assertion macros for the alarm relay output controller checker.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef ALARM_RELAY_OUTPUT_CONTROLLER_DEFINES_SVH
`define ALARM_RELAY_OUTPUT_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define AROC_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aroc checker: property failed");

// next-cycle implication
`define AROC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aroc checker: property failed");

`define AROC_ASSERT_DLY2(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("aroc checker: property failed");

`endif

[design/aroc_pkg.sv]
// Shared types and constants of the alarm relay output controller.
// No dependencies; every design module refers to it by scoped names.
package aroc_pkg;

	localparam int NUM_ALARMS = 10;
	localparam int NUM_OUTPUTS = 6;

	localparam int ALARM_W = 10;
	localparam int OUT_W = 6;
	localparam int DELAY_W = 8;
	localparam int TICK_W = 16;
	localparam int MASK_FIELD_W = 10;
	localparam int TICKS_PER_REG = 3;

	localparam int TRIG_REG_W = 60;
	localparam int DELAY_REG_W = 48;
	localparam int MODE_REG_W = 6;
	localparam int TICK_REG_W = 48;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 60;

	localparam logic [ALARM_W-1:0] ALARM_MASK = ALARM_W'((1 << NUM_ALARMS) - 1);
	localparam logic [DELAY_W-1:0] IDLE_DELAY = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRIGGER_MASKS = 3'd0,
		CFG_DELAY_RUNS = 3'd1,
		CFG_PULSE_MODE = 3'd2,
		CFG_TICKS_LOW = 3'd3,
		CFG_TICKS_HIGH = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		REQ_RUN = 1'b0,
		REQ_TICK = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic req_type;
		logic [ALARM_W-1:0] raise_mask;
		logic [ALARM_W-1:0] clear_mask;
		logic settings_reset;
	} req_t;

	typedef struct packed {
		logic [OUT_W-1:0] output_bits;
		logic [ALARM_W-1:0] alarm_bits;
		logic [ALARM_W-1:0] alarm_edges;
	} rsp_t;

	typedef struct packed {
		logic [TRIG_REG_W-1:0] trigger_masks;
		logic [DELAY_REG_W-1:0] delay_runs;
		logic [MODE_REG_W-1:0] pulse_mode_bits;
		logic [TICK_REG_W-1:0] pulse_ticks_low;
		logic [TICK_REG_W-1:0] pulse_ticks_high;
	} cfg_t;

	typedef struct packed {
		logic [MASK_FIELD_W-1:0] mask;
		logic [DELAY_W-1:0] delay;
		logic pulse;
		logic [TICK_W-1:0] ticks;
	} chan_cfg_t;

	typedef struct packed {
		logic [ALARM_W-1:0] rise;
		logic [ALARM_W-1:0] fall;
	} alarm_ev_t;

endpackage

[design/alarm_relay_output_controller.sv]
// Top level of the alarm relay output controller: input register, alarm and
// relay update logic, result register. Uses aroc_pkg, aroc_cfg, aroc_alarm, aroc_chan.
//
//   channel | signals                        | transaction
//   req     | req_valid, req_ready, req      | one run or tick item
//   rsp     | rsp_valid, rsp_ready, rsp      | relay levels, alarms, edges
//   cfg     | cfg_we, cfg_idx, cfg_data      | one register write
//
// Items pass input then result register; one item per cycle while rsp is not held.
// The state update of an item happens as it moves from the input register
// into the result register, so consecutive items see each other's state.
// A held rsp stalls the input register and drops req_ready; no skid needed.
// Reset clears alarms, relays and pulse counters; countdowns come up idle.
module alarm_relay_output_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  aroc_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output aroc_pkg::rsp_t                  rsp,
	input  logic                            cfg_we,
	input  logic [aroc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [aroc_pkg::CFG_DATA_W-1:0] cfg_data
);

	aroc_pkg::cfg_t               cfg;
	aroc_pkg::req_t               req_s1;
	logic                         valid_s1;
	aroc_pkg::rsp_t               rsp_s2;
	logic                         valid_s2;
	logic                         adv;
	logic                         is_tick;
	logic [aroc_pkg::ALARM_W-1:0] alarm_d;
	logic [aroc_pkg::ALARM_W-1:0] edges;
	aroc_pkg::alarm_ev_t          ev;
	logic [aroc_pkg::OUT_W-1:0]   relay_vec;

	assign adv = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || adv;
	assign is_tick = (req_s1.req_type == aroc_pkg::REQ_TICK);

	aroc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	aroc_alarm u_alarm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.req     (req_s1),
		.alarm_d (alarm_d),
		.edges   (edges),
		.ev      (ev)
	);

	for (genvar b = 0; b < aroc_pkg::OUT_W; b++) begin : g_out
		if (b < aroc_pkg::NUM_OUTPUTS) begin : g_chan
			aroc_pkg::chan_cfg_t ccfg;
			assign ccfg.mask = cfg.trigger_masks[aroc_pkg::MASK_FIELD_W*b +: aroc_pkg::MASK_FIELD_W];
			assign ccfg.delay = cfg.delay_runs[aroc_pkg::DELAY_W*b +: aroc_pkg::DELAY_W];
			assign ccfg.pulse = cfg.pulse_mode_bits[b];
			if (b < aroc_pkg::TICKS_PER_REG) begin : g_lo
				assign ccfg.ticks = cfg.pulse_ticks_low[aroc_pkg::TICK_W*b +: aroc_pkg::TICK_W];
			end else begin : g_hi
				assign ccfg.ticks = cfg.pulse_ticks_high[
					aroc_pkg::TICK_W*(b-aroc_pkg::TICKS_PER_REG) +: aroc_pkg::TICK_W];
			end
			aroc_chan u_chan (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (adv),
				.is_tick (is_tick),
				.ev      (ev),
				.ccfg    (ccfg),
				.relay_d (relay_vec[b])
			);
		end else begin : g_unused
			assign relay_vec[b] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2.output_bits <= relay_vec;
			rsp_s2.alarm_bits <= alarm_d;
			rsp_s2.alarm_edges <= edges;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp = rsp_s2;

endmodule

[design/aroc_cfg.sv]
// Configuration register file of the alarm relay output controller.
// Depends on aroc_pkg for register indexes and the cfg_t bundle.
module aroc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [aroc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [aroc_pkg::CFG_DATA_W-1:0] cfg_data,
	output aroc_pkg::cfg_t                  cfg
);

	aroc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				aroc_pkg::CFG_TRIGGER_MASKS: begin
					cfg_q.trigger_masks <= cfg_data[aroc_pkg::TRIG_REG_W-1:0];
				end
				aroc_pkg::CFG_DELAY_RUNS: begin
					cfg_q.delay_runs <= cfg_data[aroc_pkg::DELAY_REG_W-1:0];
				end
				aroc_pkg::CFG_PULSE_MODE: begin
					cfg_q.pulse_mode_bits <= cfg_data[aroc_pkg::MODE_REG_W-1:0];
				end
				aroc_pkg::CFG_TICKS_LOW: begin
					cfg_q.pulse_ticks_low <= cfg_data[aroc_pkg::TICK_REG_W-1:0];
				end
				aroc_pkg::CFG_TICKS_HIGH: begin
					cfg_q.pulse_ticks_high <= cfg_data[aroc_pkg::TICK_REG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/aroc_alarm.sv]
// Alarm flag register with raise/clear merge and edge detection.
// Depends on aroc_pkg for the request struct and edge bundle.
module aroc_alarm (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  aroc_pkg::req_t                req,
	output logic [aroc_pkg::ALARM_W-1:0]  alarm_d,
	output logic [aroc_pkg::ALARM_W-1:0]  edges,
	output aroc_pkg::alarm_ev_t           ev
);

	logic [aroc_pkg::ALARM_W-1:0] alarm_q;
	logic [aroc_pkg::ALARM_W-1:0] seen;

	always_comb begin
		alarm_d = alarm_q;
		seen = alarm_q;
		if (req.req_type == aroc_pkg::REQ_RUN) begin
			if (req.settings_reset) begin
				alarm_d = '0;
				seen = aroc_pkg::ALARM_MASK;
			end else begin
				alarm_d = ((alarm_q & ~req.clear_mask) | req.raise_mask) & aroc_pkg::ALARM_MASK;
			end
		end
		edges = (alarm_d ^ seen) & aroc_pkg::ALARM_MASK;
		ev.rise = edges & alarm_d;
		ev.fall = edges & ~alarm_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q <= '0;
		end else if (en) begin
			alarm_q <= alarm_d;
		end
	end

endmodule

[design/aroc_chan.sv]
// One relay output: delay countdown, pulse counter and relay level.
// Depends on aroc_pkg for the per-output config and edge bundle.
module aroc_chan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  is_tick,
	input  aroc_pkg::alarm_ev_t   ev,
	input  aroc_pkg::chan_cfg_t   ccfg,
	output logic                  relay_d
);

	logic [aroc_pkg::DELAY_W-1:0] delay_q;
	logic [aroc_pkg::DELAY_W-1:0] delay_d;
	logic [aroc_pkg::DELAY_W-1:0] delay_mid;
	logic [aroc_pkg::TICK_W-1:0]  pulse_q;
	logic [aroc_pkg::TICK_W-1:0]  pulse_d;
	logic                         relay_q;
	logic                         relay_mid;
	logic                         rise_hit;
	logic                         fall_hit;

	assign rise_hit = |(ccfg.mask & ev.rise);
	assign fall_hit = |(ccfg.mask & ev.fall);

	always_comb begin
		delay_d = delay_q;
		pulse_d = pulse_q;
		relay_d = relay_q;
		delay_mid = delay_q;
		relay_mid = relay_q;
		if (is_tick) begin
			if (pulse_q > aroc_pkg::TICK_W'(1)) begin
				pulse_d = pulse_q - aroc_pkg::TICK_W'(1);
			end else if (pulse_q == aroc_pkg::TICK_W'(1)) begin
				pulse_d = '0;
				relay_d = 1'b0;
			end
		end else begin
			if (rise_hit && delay_q == aroc_pkg::IDLE_DELAY) begin
				delay_mid = ccfg.delay;
			end
			if (fall_hit && !ccfg.pulse) begin
				relay_mid = 1'b0;
			end
			relay_d = relay_mid;
			delay_d = delay_mid;
			if (delay_mid == '0) begin
				delay_d = aroc_pkg::IDLE_DELAY;
				relay_d = 1'b1;
				if (ccfg.pulse) begin
					pulse_d = ccfg.ticks;
				end
			end else if (delay_mid != aroc_pkg::IDLE_DELAY) begin
				delay_d = delay_mid - aroc_pkg::DELAY_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= aroc_pkg::IDLE_DELAY;
			pulse_q <= '0;
			relay_q <= 1'b0;
		end else if (en) begin
			delay_q <= delay_d;
			pulse_q <= pulse_d;
			relay_q <= relay_d;
		end
	end

endmodule

[design/aroc_checker.sv]
// Port-level checker for the alarm relay output controller, bound to the top.
// Uses aroc_pkg types and the macros of alarm_relay_output_controller_defines.svh.
`include "alarm_relay_output_controller_defines.svh"

module aroc_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  aroc_pkg::rsp_t rsp
);

	`AROC_ASSERT_NEXT(a_rsp_hold_valid, rsp_valid && !rsp_ready, rsp_valid)
	`AROC_ASSERT_NEXT(a_rsp_hold_data, rsp_valid && !rsp_ready, $stable(rsp))
	`AROC_ASSERT(a_stall_only_on_backpressure, !req_ready, rsp_valid && !rsp_ready)
	`AROC_ASSERT_DLY2(a_req_reaches_rsp, req_valid && req_ready, rsp_valid)

endmodule

bind alarm_relay_output_controller aroc_checker u_aroc_checker (.*);

[tb/alarm_relay_output_controller_tb.sv]
// Self-checking testbench of the alarm relay output controller.
// Runs a directed table and random traffic through the req and rsp channels.
// Depends on aroc_pkg and the alarm_relay_output_controller RTL.
module alarm_relay_output_controller_tb;
	import aroc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 40;
	localparam int RANDOM_PHASES = 5;

	typedef enum {READY_ALWAYS, READY_MOSTLY, READY_SELDOM, READY_STUCK} ready_style_t;

	typedef struct {
		int stage;
		req_t item;
		bit typed;
		rsp_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_item = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_item;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [TRIG_REG_W-1:0] trig_cfg = '0;
	logic [DELAY_REG_W-1:0] delay_cfg = '0;
	logic [MODE_REG_W-1:0] mode_cfg = '0;
	logic [TICK_REG_W-1:0] ticks_lo_cfg = '0;
	logic [TICK_REG_W-1:0] ticks_hi_cfg = '0;

	logic [ALARM_W-1:0] alarm_now_q = '0;
	logic [ALARM_W-1:0] alarm_seen_q = '0;
	logic [DELAY_W-1:0] countdown [NUM_OUTPUTS];
	logic [TICK_W-1:0] pulse_left [NUM_OUTPUTS];
	logic [OUT_W-1:0] relay_q = '0;

	rsp_t pending_status_q [$];
	stim_row_t stim_table [$];
	rsp_t want_status;
	int error_count = 0;
	int burst_left = 0;
	int stall_left = 0;
	ready_style_t ready_style = READY_ALWAYS;
	int unsigned cycle_count = 0;

	alarm_relay_output_controller u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req_item),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp_item),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** alarm_relay_output_controller: FAILED **");
			$finish;
		end
	end

	function automatic rsp_t advance_relays(input req_t item);
		rsp_t res;
		logic [ALARM_W-1:0] changed;
		changed = '0;
		if (item.req_type == REQ_RUN) begin
			alarm_now_q = ((alarm_now_q & ~item.clear_mask) | item.raise_mask) & ALARM_MASK;
			if (item.settings_reset) begin
				alarm_now_q = '0;
				alarm_seen_q = ALARM_MASK;
			end
			changed = (alarm_now_q ^ alarm_seen_q) & ALARM_MASK;
			for (int i = 0; i < NUM_ALARMS; i++) begin
				if (changed[i]) begin
					for (int b = 0; b < NUM_OUTPUTS; b++) begin
						if (trig_cfg[MASK_FIELD_W*b + i]) begin
							if (alarm_now_q[i]) begin
								if (countdown[b] == IDLE_DELAY)
									countdown[b] = delay_cfg[DELAY_W*b +: DELAY_W];
							end else if (!mode_cfg[b]) begin
								relay_q[b] = 1'b0;
							end
						end
					end
				end
			end
			alarm_seen_q = alarm_now_q;
			for (int b = 0; b < NUM_OUTPUTS; b++) begin
				if (countdown[b] == '0) begin
					countdown[b] = IDLE_DELAY;
					relay_q[b] = 1'b1;
					if (mode_cfg[b])
						pulse_left[b] = (b < TICKS_PER_REG) ?
							ticks_lo_cfg[TICK_W*b +: TICK_W] :
							ticks_hi_cfg[TICK_W*(b-TICKS_PER_REG) +: TICK_W];
				end else if (countdown[b] != IDLE_DELAY) begin
					countdown[b] = countdown[b] - 1'b1;
				end
			end
		end else begin
			for (int b = 0; b < NUM_OUTPUTS; b++) begin
				if (pulse_left[b] > 1) begin
					pulse_left[b] = pulse_left[b] - 1'b1;
				end else if (pulse_left[b] == 1) begin
					pulse_left[b] = '0;
					relay_q[b] = 1'b0;
				end
			end
		end
		res.output_bits = relay_q;
		res.alarm_bits = alarm_now_q;
		res.alarm_edges = changed;
		return res;
	endfunction

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] trig, dly, mode, tlo, thi);
		cfg_idx_t order [5];
		logic [CFG_DATA_W-1:0] vals [5];
		order = '{CFG_TRIGGER_MASKS, CFG_DELAY_RUNS, CFG_PULSE_MODE, CFG_TICKS_LOW,
			CFG_TICKS_HIGH};
		vals = '{trig, dly, mode, tlo, thi};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= order[i];
			cfg_data <= vals[i];
			@(posedge clk);
			case (order[i])
				CFG_TRIGGER_MASKS: trig_cfg = vals[i][TRIG_REG_W-1:0];
				CFG_DELAY_RUNS:    delay_cfg = vals[i][DELAY_REG_W-1:0];
				CFG_PULSE_MODE:    mode_cfg = vals[i][MODE_REG_W-1:0];
				CFG_TICKS_LOW:     ticks_lo_cfg = vals[i][TICK_REG_W-1:0];
				CFG_TICKS_HIGH:    ticks_hi_cfg = vals[i][TICK_REG_W-1:0];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	task automatic pace();
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		end
		burst_left--;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_item(input req_t item, input bit typed, input rsp_t want);
		rsp_t predicted;
		pace();
		req_valid <= 1'b1;
		req_item <= item;
		do @(posedge clk); while (!req_ready);
		predicted = advance_relays(item);
		pending_status_q.push_back(typed ? want : predicted);
	endtask

	// hold off new transactions until every pending result is back
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_status_q.size() != 0) @(posedge clk);
	endtask

	task automatic add_row(input int stage, input req_kind_t kind,
			input logic [ALARM_W-1:0] raise, clear, input logic srst,
			input bit typed = 1'b0, input rsp_t want = '0);
		stim_row_t row;
		row.stage = stage;
		row.item.req_type = kind;
		row.item.raise_mask = raise;
		row.item.clear_mask = clear;
		row.item.settings_reset = srst;
		row.typed = typed;
		row.want = want;
		stim_table.push_back(row);
	endtask

	task automatic check_field(input string field, input logic [15:0] want, got);
		if (got !== want) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: %s expected %h, got %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (pending_status_q.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("%0t: unexpected result, expected none, got %h", $time,
							rsp_item);
				end else begin
					want_status = pending_status_q.pop_front();
					check_field("output_bits", 16'(want_status.output_bits),
						16'(rsp_item.output_bits));
					check_field("alarm_bits", 16'(want_status.alarm_bits),
						16'(rsp_item.alarm_bits));
					check_field("alarm_edges", 16'(want_status.alarm_edges),
						16'(rsp_item.alarm_edges));
				end
			end
			if (stall_left == 0) begin
				ready_style = ready_style_t'($urandom_range(0, 3));
				stall_left = $urandom_range(20, 150);
			end
			stall_left--;
			case (ready_style)
				READY_ALWAYS: rsp_ready <= 1'b1;
				READY_MOSTLY: rsp_ready <= ($urandom_range(0, 4) != 0);
				READY_SELDOM: rsp_ready <= ($urandom_range(0, 9) < 3);
				default:      rsp_ready <= ($urandom_range(0, 11) == 0);
			endcase
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] trig_v, dly_v, mode_v, tlo_v, thi_v;
		logic [TICK_W-1:0] tk;
		int sel;
		int stage;
		req_t item;

		for (int b = 0; b < NUM_OUTPUTS; b++) begin
			countdown[b] = IDLE_DELAY;
			pulse_left[b] = '0;
		end

		add_row(0, REQ_RUN, 10'h3FF, 10'h000, 1'b0, 1'b1, {6'h00, 10'h3FF, 10'h3FF});
		add_row(0, REQ_RUN, 10'h000, 10'h3FF, 1'b0, 1'b1, {6'h00, 10'h000, 10'h3FF});
		add_row(0, REQ_RUN, 10'h3FF, 10'h3FF, 1'b0, 1'b1, {6'h00, 10'h3FF, 10'h3FF});
		add_row(0, REQ_RUN, 10'h000, 10'h000, 1'b0, 1'b1, {6'h00, 10'h3FF, 10'h000});
		add_row(0, REQ_RUN, 10'h3FF, 10'h000, 1'b1, 1'b1, {6'h00, 10'h000, 10'h3FF});
		add_row(0, REQ_RUN, 10'h000, 10'h000, 1'b1, 1'b1, {6'h00, 10'h000, 10'h3FF});
		add_row(0, REQ_TICK, 10'h3FF, 10'h3FF, 1'b1, 1'b1, {6'h00, 10'h000, 10'h000});
		add_row(0, REQ_RUN, 10'h155, 10'h000, 1'b0, 1'b1, {6'h00, 10'h155, 10'h155});
		add_row(0, REQ_RUN, 10'h2AA, 10'h155, 1'b0, 1'b1, {6'h00, 10'h2AA, 10'h3FF});
		add_row(1, REQ_RUN, 10'h000, 10'h3FF, 1'b0);
		add_row(1, REQ_RUN, 10'h001, 10'h000, 1'b0);
		add_row(1, REQ_RUN, 10'h002, 10'h000, 1'b0);
		add_row(1, REQ_RUN, 10'h000, 10'h000, 1'b0);
		add_row(1, REQ_RUN, 10'h000, 10'h000, 1'b0);
		add_row(1, REQ_TICK, 10'h000, 10'h000, 1'b0);
		add_row(1, REQ_TICK, 10'h000, 10'h000, 1'b0);
		add_row(1, REQ_RUN, 10'h200, 10'h000, 1'b0);
		add_row(1, REQ_RUN, 10'h000, 10'h000, 1'b0);
		add_row(1, REQ_RUN, 10'h000, 10'h000, 1'b0);
		add_row(1, REQ_RUN, 10'h000, 10'h001, 1'b0);
		add_row(1, REQ_RUN, 10'h3FF, 10'h000, 1'b0);
		add_row(1, REQ_TICK, 10'h000, 10'h000, 1'b0);
		add_row(1, REQ_RUN, 10'h000, 10'h3FF, 1'b0);
		add_row(1, REQ_RUN, 10'h3FF, 10'h000, 1'b1);
		add_row(1, REQ_TICK, 10'h000, 10'h000, 1'b0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apply_settings('0, '0, '0, '0, '0);

		stage = 0;
		foreach (stim_table[r]) begin
			if (stim_table[r].stage != stage) begin
				drain();
				stage = stim_table[r].stage;
				apply_settings({10'h3FF, 10'h001, 10'h200, 10'h3FF, 10'h002, 10'h001},
					{8'd3, 8'd0, 8'd1, 8'd255, 8'd2, 8'd0},
					6'h3A,
					48'hFFFF_0001_0000,
					48'hFFFF_0002_0000);
			end
			send_item(stim_table[r].item, stim_table[r].typed, stim_table[r].want);
		end
		drain();

		for (int p = 0; p < RANDOM_PHASES + 2; p++) begin
			if (p == 0) begin
				trig_v = '1;
				dly_v = '1;
				mode_v = '1;
				tlo_v = '1;
				thi_v = '1;
			end else if (p == 1) begin
				trig_v = '1;
				dly_v = '0;
				mode_v = '0;
				tlo_v = '0;
				thi_v = '0;
			end else begin
				trig_v = CFG_DATA_W'({$urandom, $urandom});
				if ($urandom_range(0, 1))
					trig_v = trig_v & CFG_DATA_W'({$urandom, $urandom});
				dly_v = '0;
				tlo_v = '0;
				thi_v = '0;
				for (int b = 0; b < NUM_OUTPUTS; b++) begin
					sel = $urandom_range(0, 9);
					dly_v[DELAY_W*b +: DELAY_W] = (sel < 6) ? DELAY_W'(sel) :
						(sel < 8) ? IDLE_DELAY : DELAY_W'($urandom_range(0, 254));
					tk = ($urandom_range(0, 9) < 8) ? TICK_W'($urandom_range(0, 6)) :
						TICK_W'($urandom);
					if (b < TICKS_PER_REG)
						tlo_v[TICK_W*b +: TICK_W] = tk;
					else
						thi_v[TICK_W*(b-TICKS_PER_REG) +: TICK_W] = tk;
				end
				mode_v = CFG_DATA_W'($urandom_range(0, 63));
			end
			apply_settings(trig_v, dly_v, mode_v, tlo_v, thi_v);
			repeat ((p < 2) ? 50 : 70) begin
				item.req_type = ($urandom_range(0, 9) < 3) ? REQ_TICK : REQ_RUN;
				item.raise_mask = ALARM_W'($urandom_range(0, 1023) & $urandom_range(0, 1023));
				item.clear_mask = ALARM_W'($urandom_range(0, 1023) & $urandom_range(0, 1023));
				if ($urandom_range(0, 3) == 0)
					item.raise_mask = ALARM_W'($urandom_range(0, 1023));
				if ($urandom_range(0, 3) == 0)
					item.clear_mask = ALARM_W'($urandom_range(0, 1023));
				item.settings_reset = ($urandom_range(0, 19) == 0);
				send_item(item, 1'b0, '0);
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("** alarm_relay_output_controller: PASSED **");
		else
			$display("** alarm_relay_output_controller: FAILED **");
		$finish;
	end

endmodule
